// File: rtl/frustum_point_cull_macros.svh
// Assertion helpers for the point cull block.
`ifndef FRUSTUM_POINT_CULL_MACROS_SVH
`define FRUSTUM_POINT_CULL_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define FPC_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FPC_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: rtl/fpc_pkg.sv
`timescale 1ns / 1ps

package fpc_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int INDEX_WIDTH = 4;
   localparam int PLANE_COUNT = 6;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF = 16;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_TEST = 1'b1
   } req_kind_type;

   // Matrix row combined with row 3 for each plane, and whether it is subtracted.
   localparam logic [1:0] PLANE_ROW [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [PLANE_COUNT-1:0] PLANE_NEG = 6'b100110;

endpackage

// File: rtl/frustum_point_cull.sv
`timescale 1ns / 1ps
// Test results pass the s1, s2 and output registers. Throughput: one item per
// cycle while the output is not stalled; the twelve row-by-coordinate products
// are formed in parallel in the first stage; the stream never waits on them.
// A load is written into the matrix at its transfer and yields no result.
// Synchronous active-high reset clears the matrix to zero and empties the pipe.
`include "frustum_point_cull_macros.svh"

module frustum_point_cull
   import fpc_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [INDEX_WIDTH-1:0] req_element_index,
   input  logic [FIELD_WIDTH-1:0] req_matrix_value,
   input  logic [FIELD_WIDTH-1:0] req_point_x,
   input  logic [FIELD_WIDTH-1:0] req_point_y,
   input  logic [FIELD_WIDTH-1:0] req_point_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_inside_res
);

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W;
   localparam int DW = W + FRACTION_BITS;
   localparam int RW = ((PW > DW) ? PW : DW) + 2;
   localparam int SW = RW + 1;

   logic [W-1:0] matrix_ff [4][4];

   logic                   s1_valid_ff, s1_valid_in;
   logic signed [PW-1:0]   prod_ff [4][3];
   logic signed [PW-1:0]   prod_in [4][3];
   logic signed [W-1:0]    d_ff [4];
   logic signed [W-1:0]    d_in [4];
   logic [PLANE_COUNT-1:0] zero1_ff, zero1_in;

   logic                   s2_valid_ff;
   logic signed [RW-1:0]   row_ff [4];
   logic signed [RW-1:0]   row_in [4];
   logic [PLANE_COUNT-1:0] zero2_ff;

   logic out_valid_ff;
   logic out_inside_ff, out_inside_in;

   logic advance;
   logic load_xfer;

   // The whole pipe moves together whenever the output slot is free or drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign load_xfer = req_valid && req_ready && (req_type == REQ_LOAD);

   assign rsp_valid      = out_valid_ff;
   assign rsp_inside_res = out_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               matrix_ff[r][c] <= '0;
            end
         end
      end else if (load_xfer) begin
         matrix_ff[req_element_index[3:2]][req_element_index[1:0]] <=
            req_matrix_value[W-1:0];
      end
   end

   // Stage 1: products of each matrix row with the point, taken from the matrix
   // as it stands at the transfer, plus the zero-normal flags of each plane.
   always_comb begin
      logic signed [W-1:0] pt [3];
      logic signed [W:0]   coef;
      logic                all_zero;
      pt[0] = signed'(req_point_x[W-1:0]);
      pt[1] = signed'(req_point_y[W-1:0]);
      pt[2] = signed'(req_point_z[W-1:0]);
      s1_valid_in = req_valid && (req_type == REQ_TEST);
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[r][j] = signed'(matrix_ff[r][j]) * pt[j];
         end
         d_in[r] = signed'(matrix_ff[r][3]);
      end
      for (int k = 0; k < PLANE_COUNT; k++) begin
         all_zero = 1'b1;
         for (int j = 0; j < 3; j++) begin
            if (PLANE_NEG[k]) begin
               coef = (W+1)'(signed'(matrix_ff[3][j]))
                    - (W+1)'(signed'(matrix_ff[PLANE_ROW[k]][j]));
            end else begin
               coef = (W+1)'(signed'(matrix_ff[3][j]))
                    + (W+1)'(signed'(matrix_ff[PLANE_ROW[k]][j]));
            end
            if (coef != '0) begin
               all_zero = 1'b0;
            end
         end
         zero1_in[k] = all_zero;
      end
   end

   // Stage 2: exact dot product of each row with (x, y, z, 1).
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_in[r] = RW'(prod_ff[r][0]) + RW'(prod_ff[r][1]) + RW'(prod_ff[r][2])
                   + (RW'(d_ff[r]) <<< FRACTION_BITS);
      end
   end

   // Stage 3: each plane is row 3 plus or minus another row.
   always_comb begin
      logic signed [SW-1:0] plane_sum;
      logic [PLANE_COUNT-1:0] reject;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         if (PLANE_NEG[k]) begin
            plane_sum = SW'(row_ff[3]) - SW'(row_ff[PLANE_ROW[k]]);
         end else begin
            plane_sum = SW'(row_ff[3]) + SW'(row_ff[PLANE_ROW[k]]);
         end
         reject[k] = plane_sum[SW-1] && !zero2_ff[k];
      end
      out_inside_in = ~|reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff       <= prod_in;
         d_ff          <= d_in;
         zero1_ff      <= zero1_in;
         row_ff        <= row_in;
         zero2_ff      <= zero1_ff;
         out_inside_ff <= out_inside_in;
      end
   end

   `FPC_ASSERT_NEXT(a_load_no_result, clock, reset, load_xfer, !s1_valid_ff, "load entered pipe")
   `FPC_ASSERT_SAME(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "bad stall")
   `FPC_ASSERT_NEXT(a_load_written, clock, reset, load_xfer, matrix_ff[$past(req_element_index[3:2])][$past(req_element_index[1:0])] == $past(req_matrix_value[W-1:0]), "load lost")

endmodule
